@@ design/cit_pkg.sv @@
`default_nettype none
package cit_pkg;

  localparam int VelW     = 24;
  localparam int DeltaW   = 17;
  localparam int SensW    = 12;
  localparam int PosW     = 16;
  localparam int SensFrac = 8;
  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 2;

  localparam logic signed [VelW-1:0] VelMax = {1'b0, {(VelW-1){1'b1}}};
  localparam logic signed [VelW-1:0] VelMin = {1'b1, {(VelW-1){1'b0}}};

  localparam logic [7:0] FrictionNum = 8'd205;

  localparam logic [SensW-1:0] SensReset   = 12'd512;
  localparam logic [PosW-1:0]  RightReset  = 16'd1919;
  localparam logic [PosW-1:0]  BottomReset = 16'd1079;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENSITIVITY   = 2'd0,
    CFG_SCREEN_RIGHT  = 2'd1,
    CFG_SCREEN_BOTTOM = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_DELTA = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef struct packed {
    logic                   above;
    logic [PosW-1:0]        pos_move;
    logic signed [VelW-1:0] vel_friction;
    logic signed [VelW-1:0] vel_delta;
  } axis_res_t;

endpackage
`default_nettype wire

@@ design/cit_axis.sv @@
`default_nettype none
module cit_axis #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic signed [cit_pkg::DeltaW-1:0] delta,
  input  wire logic [cit_pkg::SensW-1:0]         sens,
  input  wire logic signed [cit_pkg::VelW-1:0]   vel,
  input  wire logic [cit_pkg::PosW-1:0]          pos,
  input  wire logic [cit_pkg::PosW-1:0]          limit,
  output cit_pkg::axis_res_t                     res
);

  localparam int VW = cit_pkg::VelW;
  localparam int PW = cit_pkg::PosW;
  localparam int DW = cit_pkg::DeltaW;
  localparam int SW = cit_pkg::SensW;
  localparam int SF = cit_pkg::SensFrac;
  localparam int ProdW = DW + SW;
  localparam int ThrW  = VW + 4;
  localparam int SumW  = VW + 2;

  logic              vneg;
  logic [VW-1:0]     vmag;
  logic [ThrW-1:0]   thr_lhs;
  logic [VW:0]       step_mag;
  logic signed [SumW-1:0] step_s;
  logic signed [SumW-1:0] pos_sum;
  logic [31:0]       fr_prod;
  logic [VW-1:0]     fr_mag;
  logic signed [ProdW-1:0] dprod;
  logic [ProdW-2:0]  dmag;
  logic [ProdW-2:0]  dscaled;
  logic signed [SumW-1:0] dstep;
  logic signed [SumW-1:0] vsum;

  always_comb begin
    vneg     = vel[VW-1];
    vmag     = vneg ? VW'(-vel) : VW'(vel);
    thr_lhs  = {4'b0, vmag} * ThrW'(10);
    res.above = thr_lhs > (ThrW'(1) << FRACTION_BITS);

    step_mag = ({1'b0, vmag} + ((VW+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    step_s   = vneg ? -$signed(SumW'(step_mag)) : $signed(SumW'(step_mag));
    pos_sum  = $signed(SumW'(pos)) + step_s;
    if (pos_sum < 0) begin
      res.pos_move = '0;
    end else if (pos_sum > $signed(SumW'(limit))) begin
      res.pos_move = limit;
    end else begin
      res.pos_move = pos_sum[PW-1:0];
    end

    fr_prod = 32'(vmag) * 32'(cit_pkg::FrictionNum);
    fr_mag  = fr_prod[VW+7:8];
    res.vel_friction = vneg ? -$signed(fr_mag) : $signed(fr_mag);

    dprod   = $signed(ProdW'(delta)) * $signed(ProdW'({1'b0, sens}));
    dmag    = dprod[ProdW-1] ? (ProdW-1)'(-dprod) : (ProdW-1)'(dprod);
    dscaled = (dmag + ((ProdW-1)'(1) << (SF - 1))) >> SF;
    dstep   = dprod[ProdW-1] ? -$signed(SumW'(dscaled)) : $signed(SumW'(dscaled));
    vsum    = $signed(SumW'(vel)) + dstep;
    if (vsum > $signed(SumW'(cit_pkg::VelMax))) begin
      res.vel_delta = cit_pkg::VelMax;
    end else if (vsum < $signed(SumW'(cit_pkg::VelMin))) begin
      res.vel_delta = cit_pkg::VelMin;
    end else begin
      res.vel_delta = vsum[VW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ design/cursor_inertia_tracker.sv @@
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   in_action, in_delta_x, in_delta_y
// out      source     out_valid/out_stall out_cursor_x, out_cursor_y, out_moved, out_active
// cfg      sink       cfg_wr_en           cfg_index, cfg_wdata
//
// One item per cycle unless out_stall holds a result; registers: input, then result.
// The input register feeds one pass of per-axis multiply, round and clamp logic
// that updates velocity, position and the result register together.
// Synchronous active-low reset clears state and loads register defaults.
// in_stall rises only while a result waits under out_stall and an item is held.
module cursor_inertia_tracker #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_action,
  input  wire logic signed [cit_pkg::DeltaW-1:0]   in_delta_x,
  input  wire logic signed [cit_pkg::DeltaW-1:0]   in_delta_y,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [cit_pkg::PosW-1:0]                 out_cursor_x,
  output logic [cit_pkg::PosW-1:0]                 out_cursor_y,
  output logic                                     out_moved,
  output logic                                     out_active,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cit_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [cit_pkg::CfgW-1:0]            cfg_wdata
);

  localparam int VW = cit_pkg::VelW;
  localparam int PW = cit_pkg::PosW;

  logic                   s1_valid_r;
  logic                   action_r;
  logic signed [cit_pkg::DeltaW-1:0] dx_r, dy_r;
  logic [cit_pkg::SensW-1:0] sens_r;
  logic [PW-1:0]          right_r, bottom_r;
  logic signed [VW-1:0]   vel_x_r, vel_y_r, vel_x_nxt, vel_y_nxt;
  logic [PW-1:0]          pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic                   active_r, active_nxt, moved_nxt;
  logic                   out_valid_r;
  logic [PW-1:0]          out_x_r, out_y_r;
  logic                   out_moved_r, out_active_r;
  logic                   s1_adv;
  cit_pkg::axis_res_t     res_x, res_y;

  cit_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
    .delta(dx_r), .sens(sens_r), .vel(vel_x_r), .pos(pos_x_r), .limit(right_r), .res(res_x)
  );

  cit_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
    .delta(dy_r), .sens(sens_r), .vel(vel_y_r), .pos(pos_y_r), .limit(bottom_r), .res(res_y)
  );

  assign s1_adv   = s1_valid_r & ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;

  always_comb begin
    vel_x_nxt  = vel_x_r;
    vel_y_nxt  = vel_y_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    active_nxt = active_r;
    moved_nxt  = 1'b0;
    if (action_r == cit_pkg::ACT_DELTA) begin
      vel_x_nxt  = res_x.vel_delta;
      vel_y_nxt  = res_y.vel_delta;
      active_nxt = 1'b1;
    end else if (res_x.above || res_y.above) begin
      pos_x_nxt = res_x.pos_move;
      pos_y_nxt = res_y.pos_move;
      moved_nxt = (res_x.pos_move != pos_x_r) || (res_y.pos_move != pos_y_r);
      vel_x_nxt = res_x.vel_friction;
      vel_y_nxt = res_y.vel_friction;
    end else begin
      vel_x_nxt  = '0;
      vel_y_nxt  = '0;
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= cit_pkg::SensReset;
      right_r  <= cit_pkg::RightReset;
      bottom_r <= cit_pkg::BottomReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cit_pkg::CFG_SENSITIVITY:   sens_r   <= cfg_wdata[cit_pkg::SensW-1:0];
        cit_pkg::CFG_SCREEN_RIGHT:  right_r  <= cfg_wdata[PW-1:0];
        cit_pkg::CFG_SCREEN_BOTTOM: bottom_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      active_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        vel_x_r     <= vel_x_nxt;
        vel_y_r     <= vel_y_nxt;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        active_r    <= active_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      action_r <= in_action;
      dx_r     <= in_delta_x;
      dy_r     <= in_delta_y;
    end
    if (s1_adv) begin
      out_x_r      <= pos_x_nxt;
      out_y_r      <= pos_y_nxt;
      out_moved_r  <= moved_nxt;
      out_active_r <= active_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cursor_x = out_x_r;
  assign out_cursor_y = out_y_r;
  assign out_moved    = out_moved_r;
  assign out_active   = out_active_r;

endmodule
`default_nettype wire

@@ design/cit_checker.sv @@
`default_nettype none
module cit_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [cit_pkg::PosW-1:0]   out_cursor_x,
  input wire logic [cit_pkg::PosW-1:0]   out_cursor_y,
  input wire logic                       out_moved,
  input wire logic                       out_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y)
      && $stable(out_moved) && $stable(out_active))
    else $error("stalled result changed");

  a_moved_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> out_active)
    else $error("move reported while idle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind cursor_inertia_tracker cit_checker u_cit_checker (.*);
`default_nettype wire
